// ===== rtl/core/teq_pkg.sv =====
// Package of the timed event queue: sizes, codes, field types and the slot record.
// No dependencies; the core and its checker use it through scoped names.
package teq_pkg;

  localparam int EVENT_SLOTS  = 16;
  localparam int SLOT_BITS    = $clog2(EVENT_SLOTS);
  localparam int FUNC_ID_BITS = 8;

  localparam logic [63:0] EARLIEST_RESET = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] EMPTY_EARLIEST = 64'h7FFF_FFFF_0000_0000;
  localparam logic [8:0]  NUM_FUNC_RESET = 9'd1;
  localparam logic [7:0]  RUN_LIMIT_RESET = 8'd32;

  // input modes
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_DEL  = 2'd1;
  localparam logic [1:0] MODE_STEP = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;
  localparam logic [1:0] KIND_FIRE = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_FUNC  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // register indexes
  localparam logic REG_NUM_FUNC  = 1'b0;
  localparam logic REG_RUN_LIMIT = 1'b1;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] param;
    logic [63:0] due;
    logic [7:0]  func;
  } slot_rec_t;

endpackage

// ===== rtl/core/timed_event_queue.sv =====
// Top level of the timed event queue: stream in/out channels, APB registers, slot memory.
// Depends on teq_pkg.
//
// The block holds up to EVENT_SLOTS pending events in a synchronous memory
// (one write port, one read port, registered read) plus a valid bit per
// slot in flops. Every request is taken one at a time; in_tready is high only
// while the block is idle. An add needs no sweep of the memory and a delete
// needs one. A step on an empty table, or one whose advanced time is still
// short of the earliest due time, needs none; any other step makes one sweep
// that marks the due events and finds the new earliest time, then one sweep
// per fired event that picks the lowest id among those still marked. The
// memory read port, one slot per cycle, paces every sweep. Results leave
// through a one-deep output register; a stalled result channel holds the
// core in its emit state for as long as it stalls. Write the registers only
// while the block is idle; a write takes effect at its access edge.
module timed_event_queue (
  input  logic         clk,
  input  logic         rst_n,
  // request channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // mode
  input  logic [135:0] in_tdata,   // func_id[7:0], delta[39:8], event_param[103:40],
                                   // target_id[135:104]
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // kind
  output logic [183:0] out_tdata,  // status[2:0], new_id[34:3], fired_func[42:35],
                                   // fired_param[106:43], run_amount[114:107],
                                   // now_count[177:115], zero pad[183:178]
  output logic         out_tlast,
  // register port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int N = teq_pkg::EVENT_SLOTS;
  localparam int SB = teq_pkg::SLOT_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_DEL, S_RUN, S_TEST, S_SCAN, S_SEL, S_EMIT
  } state_t;

  state_t state_r;
  state_t ret_r;

  // configuration
  logic [8:0] num_func_r;
  logic [7:0] run_limit_r;

  // scheduler state
  logic [N-1:0]  valid_r;
  logic [N-1:0]  fire_r;
  logic [62:0]   master_r;
  logic [63:0]   earliest_r;
  logic [63:0]   min_due_r;
  logic [31:0]   next_id_r;
  logic [7:0]    run_r;

  // captured request
  logic [7:0]    func_in_r;
  logic [31:0]   delta_r;
  logic [63:0]   param_in_r;
  logic [31:0]   target_r;

  // sweep over the memory
  logic [SB:0]   cnt_r;
  logic          q_live_r;
  logic [SB-1:0] q_idx_r;
  teq_pkg::slot_rec_t q_rec;
  logic          found_r;
  logic          have_r;
  logic [SB-1:0] best_idx_r;
  logic [31:0]   best_id_r;
  logic [7:0]    best_func_r;
  logic [63:0]   best_param_r;

  // pending result
  logic [1:0]    res_kind_r;
  logic [2:0]    res_status_r;
  logic [31:0]   res_id_r;
  logic [7:0]    res_func_r;
  logic [63:0]   res_param_r;
  logic [7:0]    res_run_r;
  logic          res_last_r;

  // output register
  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [177:0]  out_data_r;
  logic          out_last_r;

  // slot memory
  teq_pkg::slot_rec_t mem [N];
  logic               mem_we;
  logic [SB-1:0]      mem_waddr;
  teq_pkg::slot_rec_t mem_wdata;

  // ---------------- register port ----------------
  assign cfg_pready = 1'b1;
  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[2])
      teq_pkg::REG_NUM_FUNC:  cfg_prdata = {23'd0, num_func_r};
      default:                cfg_prdata = {24'd0, run_limit_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_func_r  <= teq_pkg::NUM_FUNC_RESET;
      run_limit_r <= teq_pkg::RUN_LIMIT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == teq_pkg::REG_NUM_FUNC) begin
        num_func_r <= cfg_pwdata[8:0];
      end else begin
        run_limit_r <= cfg_pwdata[7:0];
      end
    end
  end

  // ---------------- handshakes ----------------
  logic in_acc;
  logic out_free;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'd0, out_data_r};
  assign out_tlast  = out_last_r;

  // ---------------- memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    q_rec <= mem[cnt_r[SB-1:0]];
  end

  // ---------------- add decision ----------------
  logic          func_bad;
  logic          have_free;
  logic [SB-1:0] free_idx;
  logic [63:0]   add_due;

  always_comb begin
    func_bad = ({1'b0, func_in_r} >= num_func_r) ||
               ((9'(func_in_r) >> teq_pkg::FUNC_ID_BITS) != 9'd0);
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        have_free = 1'b1;
        free_idx  = SB'(i);
      end
    end
    add_due   = {1'b0, master_r} + {32'd0, delta_r};
    mem_we    = (state_r == S_ADD) && !func_bad && have_free;
    mem_waddr = free_idx;
    mem_wdata = '{id: next_id_r, param: param_in_r, due: add_due, func: func_in_r};
  end

  // ---------------- sweep helpers ----------------
  logic          sweep_done;
  logic          del_hit;
  logic          take_q;
  logic [SB-1:0] best_idx_now;
  logic [31:0]   best_id_now;
  logic [7:0]    best_func_now;
  logic [63:0]   best_param_now;
  logic [N-1:0]  fire_left;
  logic [63:0]   run_sum;

  always_comb begin
    sweep_done = (cnt_r == (SB+1)'(N)) && q_live_r;
    del_hit    = q_live_r && valid_r[q_idx_r] && (q_rec.id == target_r) && !found_r;
    take_q     = q_live_r && fire_r[q_idx_r] && (!have_r || (q_rec.id < best_id_r));
    best_idx_now   = take_q ? q_idx_r     : best_idx_r;
    best_id_now    = take_q ? q_rec.id    : best_id_r;
    best_func_now  = take_q ? q_rec.func  : best_func_r;
    best_param_now = take_q ? q_rec.param : best_param_r;
    fire_left  = fire_r & ~(N'(1) << best_idx_now);
    run_sum    = {1'b0, master_r} + {56'd0, run_limit_r};
  end

  // ---------------- control and datapath ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      valid_r     <= '0;
      fire_r      <= '0;
      master_r    <= '0;
      earliest_r  <= teq_pkg::EARLIEST_RESET;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
      q_live_r    <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // drop the taken result unless the emit state refills the register
      if (out_valid_r && out_tready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      // advance the sweep counter in sweep states; the final slot hands over to the FSM
      if ((state_r == S_DEL || state_r == S_SCAN || state_r == S_SEL) && !sweep_done) begin
        q_live_r <= (cnt_r < (SB+1)'(N));
        q_idx_r  <= cnt_r[SB-1:0];
        if (cnt_r < (SB+1)'(N)) begin
          cnt_r <= cnt_r + (SB+1)'(1);
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            func_in_r  <= in_tdata[7:0];
            delta_r    <= in_tdata[39:8];
            param_in_r <= in_tdata[103:40];
            target_r   <= in_tdata[135:104];
            cnt_r      <= '0;
            q_live_r   <= 1'b0;
            found_r    <= 1'b0;
            case (in_tuser)
              teq_pkg::MODE_ADD:  state_r <= S_ADD;
              teq_pkg::MODE_DEL:  state_r <= S_DEL;
              teq_pkg::MODE_STEP: state_r <= S_RUN;
              default:            state_r <= S_IDLE;  // reserved: drop
            endcase
          end
        end

        S_ADD: begin
          res_kind_r  <= teq_pkg::KIND_ADD;
          res_func_r  <= '0;
          res_param_r <= '0;
          res_run_r   <= '0;
          res_last_r  <= 1'b1;
          res_id_r    <= '0;
          if (func_bad) begin
            res_status_r <= teq_pkg::ST_BAD_FUNC;
          end else if (!have_free) begin
            res_status_r <= teq_pkg::ST_FULL;
          end else begin
            res_status_r      <= teq_pkg::ST_OK;
            res_id_r          <= next_id_r;
            next_id_r         <= next_id_r + 32'd1;
            valid_r[free_idx] <= 1'b1;
            if (add_due < earliest_r) begin
              earliest_r <= add_due;
            end
          end
          ret_r   <= S_IDLE;
          state_r <= S_EMIT;
        end

        S_DEL: begin
          if (del_hit) begin
            found_r          <= 1'b1;
            valid_r[q_idx_r] <= 1'b0;
          end
          if (sweep_done) begin
            res_kind_r   <= teq_pkg::KIND_DEL;
            res_status_r <= (found_r || del_hit) ? teq_pkg::ST_OK : teq_pkg::ST_NOT_FOUND;
            res_id_r     <= '0;
            res_func_r   <= '0;
            res_param_r  <= '0;
            res_run_r    <= '0;
            res_last_r   <= 1'b1;
            ret_r        <= S_IDLE;
            state_r      <= S_EMIT;
          end
        end

        S_RUN: begin
          res_kind_r  <= teq_pkg::KIND_IDLE;
          res_id_r    <= '0;
          res_func_r  <= '0;
          res_param_r <= '0;
          res_last_r  <= 1'b1;
          if (valid_r == '0) begin
            res_status_r <= teq_pkg::ST_EMPTY;
            res_run_r    <= '0;
            ret_r        <= S_IDLE;
            state_r      <= S_EMIT;
          end else if (run_sum <= earliest_r) begin
            run_r    <= run_limit_r;
            master_r <= master_r + {55'd0, run_limit_r};
            state_r  <= S_TEST;
          end else if (earliest_r > {1'b0, master_r}) begin
            run_r    <= 8'(earliest_r - {1'b0, master_r});
            master_r <= master_r + 63'(earliest_r[7:0] - master_r[7:0]);
            state_r  <= S_TEST;
          end else begin
            run_r   <= '0;
            state_r <= S_TEST;
          end
        end

        S_TEST: begin
          res_status_r <= teq_pkg::ST_OK;
          res_run_r    <= run_r;
          if ({1'b0, master_r} >= earliest_r) begin
            fire_r    <= '0;
            min_due_r <= teq_pkg::EMPTY_EARLIEST;
            cnt_r     <= '0;
            q_live_r  <= 1'b0;
            state_r   <= S_SCAN;
          end else begin
            ret_r   <= S_IDLE;
            state_r <= S_EMIT;
          end
        end

        S_SCAN: begin
          // mark due events, track the least remaining due time
          if (q_live_r && valid_r[q_idx_r]) begin
            if (q_rec.due <= earliest_r) begin
              fire_r[q_idx_r] <= 1'b1;
            end else if (q_rec.due < min_due_r) begin
              min_due_r <= q_rec.due;
            end
          end
          if (sweep_done) begin
            if (q_live_r && valid_r[q_idx_r] && q_rec.due > earliest_r &&
                q_rec.due < min_due_r) begin
              earliest_r <= q_rec.due;
            end else begin
              earliest_r <= min_due_r;
            end
            cnt_r    <= '0;
            q_live_r <= 1'b0;
            have_r   <= 1'b0;
            if (fire_r == '0 && !(q_live_r && valid_r[q_idx_r] &&
                                  q_rec.due <= earliest_r)) begin
              ret_r   <= S_IDLE;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_SEL;
            end
          end
        end

        S_SEL: begin
          if (take_q) begin
            have_r       <= 1'b1;
            best_idx_r   <= q_idx_r;
            best_id_r    <= q_rec.id;
            best_func_r  <= q_rec.func;
            best_param_r <= q_rec.param;
          end
          if (sweep_done) begin
            fire_r[best_idx_now]  <= 1'b0;
            valid_r[best_idx_now] <= 1'b0;
            res_kind_r   <= teq_pkg::KIND_FIRE;
            res_status_r <= teq_pkg::ST_OK;
            res_id_r     <= best_id_now;
            res_func_r   <= best_func_now;
            res_param_r  <= best_param_now;
            res_run_r    <= run_r;
            res_last_r   <= (fire_left == '0);
            ret_r        <= (fire_left == '0) ? S_IDLE : S_SEL;
            cnt_r        <= '0;
            q_live_r     <= 1'b0;
            have_r       <= 1'b0;
            state_r      <= S_EMIT;
          end
        end

        S_EMIT: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_last_r  <= res_last_r;
            out_data_r  <= {master_r, res_run_r, res_param_r, res_func_r,
                            res_id_r, res_status_r};
            state_r     <= ret_r;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/teq_checker.sv =====
// Port-level checker of the timed event queue, bound to the top level.
// Depends on teq_pkg and timed_event_queue.
module teq_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [1:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [1:0]   out_tuser,
  input logic [183:0] out_tdata,
  input logic         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != teq_pkg::MODE_RSVD |=> !in_tready)
    else $error("request taken while busy");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != teq_pkg::KIND_FIRE |-> out_tlast)
    else $error("single reply without last");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == teq_pkg::KIND_FIRE |-> out_tdata[2:0] == teq_pkg::ST_OK)
    else $error("fired event with error status");

endmodule

bind timed_event_queue teq_checker u_teq_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tuser(out_tuser), .out_tdata(out_tdata), .out_tlast(out_tlast)
);
